### rtl/fhse_pkg.sv
// ----------------------------------------------------------------------------
// Fix heading and speed estimator package
// Shared constants, register codes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package fhse_pkg;

   localparam int ANGLE_BITS_DEFAULT    = 16;
   localparam int POS_FRAC_BITS_DEFAULT = 16;

   localparam int POS_W    = 32;
   localparam int TIME_W   = 40;
   localparam int CFG_W    = 16;
   localparam int CSR_IDX_W = 8;
   localparam int SPEED_W  = 24;
   localparam int HEAD_W   = 16;
   localparam int DIFF_W   = POS_W + 1;

   localparam logic [SPEED_W-1:0] SPEED_MAX = {SPEED_W{1'b1}};

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_INTERVAL = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_STEP     = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADING_GAIN = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_GAIN   = 8'd3;

   localparam logic [CFG_W-1:0] MIN_INTERVAL_RESET = 16'd1000;
   localparam logic [CFG_W-1:0] MIN_STEP_RESET     = 16'd655;
   localparam logic [CFG_W-1:0] HEADING_GAIN_RESET = 16'd19661;
   localparam logic [CFG_W-1:0] SPEED_GAIN_RESET   = 16'd13107;

   localparam int CORDIC_STEPS = 31;
   localparam int CORDIC_IDX_W = $clog2(CORDIC_STEPS);
   localparam int CORDIC_W     = 36;

   // Arctangent of 2^-i, with 2^32 standing for a full turn.
   function automatic logic [31:0] atan_entry(input logic [CORDIC_IDX_W-1:0] idx);
      logic [31:0] v;
      unique case (idx)
         5'd0:  v = 32'd536870912;
         5'd1:  v = 32'd316933406;
         5'd2:  v = 32'd167458907;
         5'd3:  v = 32'd85004756;
         5'd4:  v = 32'd42667331;
         5'd5:  v = 32'd21354465;
         5'd6:  v = 32'd10679838;
         5'd7:  v = 32'd5340245;
         5'd8:  v = 32'd2670163;
         5'd9:  v = 32'd1335087;
         5'd10: v = 32'd667544;
         5'd11: v = 32'd333772;
         5'd12: v = 32'd166886;
         5'd13: v = 32'd83443;
         5'd14: v = 32'd41722;
         5'd15: v = 32'd20861;
         5'd16: v = 32'd10430;
         5'd17: v = 32'd5215;
         5'd18: v = 32'd2608;
         5'd19: v = 32'd1304;
         5'd20: v = 32'd652;
         5'd21: v = 32'd326;
         5'd22: v = 32'd163;
         5'd23: v = 32'd81;
         5'd24: v = 32'd41;
         5'd25: v = 32'd20;
         5'd26: v = 32'd10;
         5'd27: v = 32'd5;
         5'd28: v = 32'd3;
         5'd29: v = 32'd1;
         5'd30: v = 32'd1;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

endpackage

### rtl/fix_heading_speed_estimator.sv
// ----------------------------------------------------------------------------
// Fix heading and speed estimator
// Smooths heading and speed from a stream of timestamped position fixes.
// ----------------------------------------------------------------------------
// One result follows every fix. A fix that updates nothing (the first fix or
// one that comes too soon) goes straight from its transfer to the final state,
// which loads the output register. An updating fix passes, in order, through
// forming the squares, the square root at one root bit per cycle, forming the
// speed numerator and testing for saturation, the divider at one quotient bit
// per cycle, the speed filter and the load of the output register. When the
// heading moves as well, the heading step comes before that load. A speed
// sample that saturates skips the divider. The CORDIC for the motion angle runs
// 31 rotations alongside the root. A new fix is taken in the cycle after the
// previous one has reached the output register, which holds its result until
// the consumer takes it; while the consumer stalls, the sequencer waits in its
// last state.
module fix_heading_speed_estimator #(
   parameter int ANGLE_BITS    = fhse_pkg::ANGLE_BITS_DEFAULT,
   parameter int POS_FRAC_BITS = fhse_pkg::POS_FRAC_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // pos_x [31:0], pos_y [63:32], timestamp_us [103:64]
   input  logic [103:0]                       req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // heading [15:0], speed [39:16]
   output logic [39:0]                        rsp_tdata,
   // speed_updated [0], heading_updated [1]
   output logic [1:0]                         rsp_tuser,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [fhse_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [fhse_pkg::CFG_W-1:0]         csr_data
);

   localparam int NUM_SH = (POS_FRAC_BITS < 16) ? (16 - POS_FRAC_BITS) : 0;
   localparam int DEN_SH = (POS_FRAC_BITS > 16) ? (POS_FRAC_BITS - 16) : 0;
   localparam int PROD_W = 53;
   localparam int NUM_W  = PROD_W + NUM_SH;
   localparam int DEN_W  = fhse_pkg::TIME_W + DEN_SH + 24;
   localparam int DIV_W  = (NUM_W > DEN_W) ? NUM_W : DEN_W;
   localparam int HP_W   = ANGLE_BITS + 17;

   typedef enum logic [3:0] {
      S_IDLE, S_SQA, S_SQB, S_ROOT, S_NUM, S_SAT, S_DIV,
      S_FILT1, S_FILT2, S_FILT3, S_HEAD1, S_HEAD2, S_FINISH
   } state_type;

   state_type state_ff;

   logic [fhse_pkg::CFG_W-1:0] min_interval_ff, min_step_ff, heading_gain_ff, speed_gain_ff;

   logic signed [fhse_pkg::POS_W-1:0] prev_x_ff, prev_y_ff, pos_x, pos_y;
   logic [fhse_pkg::TIME_W-1:0]       prev_time_ff, timestamp, dt, dt_ff;
   logic [ANGLE_BITS-1:0]             heading_est_ff, angle, diff;
   logic [fhse_pkg::SPEED_W-1:0]      speed_est_ff, sample_ff, q_ff;
   logic                              have_fix_ff, sp_ff, hd_ff;

   logic signed [fhse_pkg::DIFF_W-1:0] dx, dy;
   logic [fhse_pkg::DIFF_W-1:0]        ax_full, ay_full;
   logic [31:0]                        ax, ay, ax_ff, ay_ff;
   logic                               do_update, big_step, accept, cordic_done;

   logic [63:0]         sq_ff, sq_y;
   logic [65:0]         rad_ff;
   logic [34:0]         rem_ff;
   logic [36:0]         rem_try, trial;
   logic [32:0]         root_ff;
   logic [5:0]          cnt_ff;
   logic [PROD_W-1:0]   num_prod;
   logic [DIV_W-1:0]    num_ff, dsh_ff;
   logic                qbit;
   logic [40:0]         p1_ff;
   logic [39:0]         p2_ff;
   logic [41:0]         facc;
   logic [25:0]         fsh;
   logic signed [HP_W-1:0] hprod_ff, hsum;

   logic [fhse_pkg::HEAD_W-1:0]  h16, rsp_heading_ff;
   logic [fhse_pkg::SPEED_W-1:0] rsp_speed_ff;
   logic                         rsp_valid_ff, rsp_sp_ff, rsp_hd_ff;

   assign pos_x     = req_tdata[31:0];
   assign pos_y     = req_tdata[63:32];
   assign timestamp = req_tdata[103:64];

   assign dx = {pos_x[31], pos_x} - {prev_x_ff[31], prev_x_ff};
   assign dy = {pos_y[31], pos_y} - {prev_y_ff[31], prev_y_ff};
   assign dt = timestamp - prev_time_ff;
   assign ax_full = dx[32] ? -dx : dx;
   assign ay_full = dy[32] ? -dy : dy;
   assign ax = ax_full[31:0];
   assign ay = ay_full[31:0];

   assign do_update = have_fix_ff && (dt > fhse_pkg::TIME_W'(min_interval_ff));
   assign big_step  = (ax > 32'(min_step_ff)) || (ay > 32'(min_step_ff));

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   fhse_cordic #(
      .ANGLE_BITS(ANGLE_BITS)
   ) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (accept && do_update && big_step),
      .vec_x (dx),
      .vec_y (dy),
      .done  (cordic_done),
      .angle (angle)
   );

   assign sq_y = ay_ff * ay_ff;

   // One root bit per cycle: bring down the next pair of radicand bits.
   assign rem_try = {rem_ff, rad_ff[65:64]};
   assign trial   = {2'b00, root_ff, 2'b01};

   assign num_prod = root_ff * 20'd1000000;
   assign qbit     = (num_ff >= dsh_ff);

   assign facc = {1'b0, p1_ff} + {2'b00, p2_ff} + 42'd32768;
   assign fsh  = facc[41:16];

   assign diff = angle - heading_est_ff;
   assign hsum = hprod_ff + HP_W'(32768);

   generate
      if (ANGLE_BITS >= 16) begin : g_head_top
         assign h16 = heading_est_ff[ANGLE_BITS-1 -: 16];
      end else begin : g_head_pad
         assign h16 = {heading_est_ff, {(16 - ANGLE_BITS){1'b0}}};
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         min_interval_ff <= fhse_pkg::MIN_INTERVAL_RESET;
         min_step_ff     <= fhse_pkg::MIN_STEP_RESET;
         heading_gain_ff <= fhse_pkg::HEADING_GAIN_RESET;
         speed_gain_ff   <= fhse_pkg::SPEED_GAIN_RESET;
         prev_x_ff       <= '0;
         prev_y_ff       <= '0;
         prev_time_ff    <= '0;
         heading_est_ff  <= '0;
         speed_est_ff    <= '0;
         have_fix_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               fhse_pkg::CSR_MIN_INTERVAL: min_interval_ff <= csr_data;
               fhse_pkg::CSR_MIN_STEP:     min_step_ff     <= csr_data;
               fhse_pkg::CSR_HEADING_GAIN: heading_gain_ff <= csr_data;
               fhse_pkg::CSR_SPEED_GAIN:   speed_gain_ff   <= csr_data;
               default: ;
            endcase
         end

         // The final state reloads the output register in the same cycle.
         if (rsp_valid_ff && rsp_tready && (state_ff != S_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  prev_x_ff    <= pos_x;
                  prev_y_ff    <= pos_y;
                  prev_time_ff <= timestamp;
                  have_fix_ff  <= 1'b1;
                  ax_ff        <= ax;
                  ay_ff        <= ay;
                  dt_ff        <= dt;
                  sp_ff        <= 1'b0;
                  hd_ff        <= do_update && big_step;
                  state_ff     <= do_update ? S_SQA : S_FINISH;
               end
            end
            S_SQA: begin
               sq_ff    <= ax_ff * ax_ff;
               state_ff <= S_SQB;
            end
            S_SQB: begin
               rad_ff   <= {2'b00, sq_ff} + {2'b00, sq_y};
               rem_ff   <= '0;
               root_ff  <= '0;
               cnt_ff   <= '0;
               state_ff <= S_ROOT;
            end
            S_ROOT: begin
               if (rem_try >= trial) begin
                  rem_ff  <= 35'(rem_try - trial);
                  root_ff <= {root_ff[31:0], 1'b1};
               end else begin
                  rem_ff  <= rem_try[34:0];
                  root_ff <= {root_ff[31:0], 1'b0};
               end
               rad_ff <= {rad_ff[63:0], 2'b00};
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == 6'd32) begin
                  state_ff <= S_NUM;
               end
            end
            S_NUM: begin
               num_ff   <= DIV_W'(num_prod) << NUM_SH;
               dsh_ff   <= DIV_W'(dt_ff) << (DEN_SH + 24);
               state_ff <= S_SAT;
            end
            S_SAT: begin
               // A quotient of 2^24 or more saturates without dividing.
               if (qbit) begin
                  sample_ff <= fhse_pkg::SPEED_MAX;
                  state_ff  <= S_FILT1;
               end else begin
                  dsh_ff   <= dsh_ff >> 1;
                  cnt_ff   <= 6'd23;
                  q_ff     <= '0;
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (qbit) begin
                  num_ff <= num_ff - dsh_ff;
               end
               q_ff   <= {q_ff[22:0], qbit};
               dsh_ff <= dsh_ff >> 1;
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == 6'd0) begin
                  sample_ff <= {q_ff[22:0], qbit};
                  state_ff  <= S_FILT1;
               end
            end
            S_FILT1: begin
               p1_ff    <= (17'd65536 - {1'b0, speed_gain_ff}) * speed_est_ff;
               state_ff <= S_FILT2;
            end
            S_FILT2: begin
               p2_ff    <= speed_gain_ff * sample_ff;
               state_ff <= S_FILT3;
            end
            S_FILT3: begin
               speed_est_ff <= (fsh > 26'(fhse_pkg::SPEED_MAX)) ? fhse_pkg::SPEED_MAX
                                                               : fsh[23:0];
               sp_ff        <= 1'b1;
               state_ff     <= hd_ff ? S_HEAD1 : S_FINISH;
            end
            S_HEAD1: begin
               if (cordic_done) begin
                  hprod_ff <= $signed({1'b0, heading_gain_ff}) * $signed(diff);
                  state_ff <= S_HEAD2;
               end
            end
            S_HEAD2: begin
               heading_est_ff <= heading_est_ff + hsum[ANGLE_BITS+15:16];
               state_ff       <= S_FINISH;
            end
            S_FINISH: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_heading_ff <= h16;
                  rsp_speed_ff   <= speed_est_ff;
                  rsp_sp_ff      <= sp_ff;
                  rsp_hd_ff      <= hd_ff;
                  state_ff       <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_speed_ff, rsp_heading_ff};
   assign rsp_tuser  = {rsp_hd_ff, rsp_sp_ff};

`ifndef SYNTHESIS
   // A fix is taken only once the previous one has left the sequencer.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("second fix taken while one is in progress");

   // The heading can only move when the speed was updated too.
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[1] && !rsp_tuser[0]))
      else $error("heading updated without speed update");

   // The CORDIC runs alongside the square root and is finished in time.
   a_cordic_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_HEAD1) |-> cordic_done)
      else $error("motion angle not ready for the heading update");
`endif

endmodule

### rtl/fhse_cordic.sv
// ----------------------------------------------------------------------------
// Vectoring CORDIC
// Finds the angle of a displacement vector, one rotation per cycle.
// ----------------------------------------------------------------------------
module fhse_cordic #(
   parameter int ANGLE_BITS = fhse_pkg::ANGLE_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [fhse_pkg::DIFF_W-1:0]  vec_x,
   input  logic signed [fhse_pkg::DIFF_W-1:0]  vec_y,
   output logic                                done,
   output logic [ANGLE_BITS-1:0]               angle
);

   localparam int RSH = (ANGLE_BITS < 32) ? (31 - ANGLE_BITS) : 0;
   localparam logic [32:0] ROUND = (ANGLE_BITS < 32) ? (33'd1 << RSH) : 33'd0;

   logic signed [fhse_pkg::CORDIC_W-1:0] x_ff, y_ff, xs, ys, sx, sy;
   logic [31:0]                          acc_ff;
   logic [fhse_pkg::CORDIC_IDX_W-1:0]    iter_ff;
   logic                                 run_ff, done_ff;
   logic [32:0]                          rounded;

   assign sx = fhse_pkg::CORDIC_W'(vec_x);
   assign sy = fhse_pkg::CORDIC_W'(vec_y);
   assign xs = x_ff >>> iter_ff;
   assign ys = y_ff >>> iter_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else if (start) begin
         run_ff  <= 1'b1;
         done_ff <= 1'b0;
         iter_ff <= '0;
         // Vectors in the left half plane are turned through a half turn first.
         if (vec_x < 0) begin
            x_ff   <= -sx;
            y_ff   <= -sy;
            acc_ff <= 32'h8000_0000;
         end else begin
            x_ff   <= sx;
            y_ff   <= sy;
            acc_ff <= 32'd0;
         end
      end else if (run_ff) begin
         if (y_ff > 0) begin
            x_ff   <= x_ff + ys;
            y_ff   <= y_ff - xs;
            acc_ff <= acc_ff + fhse_pkg::atan_entry(iter_ff);
         end else begin
            x_ff   <= x_ff - ys;
            y_ff   <= y_ff + xs;
            acc_ff <= acc_ff - fhse_pkg::atan_entry(iter_ff);
         end
         if (iter_ff == fhse_pkg::CORDIC_IDX_W'(fhse_pkg::CORDIC_STEPS - 1)) begin
            run_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
         iter_ff <= iter_ff + 1'b1;
      end
   end

   assign rounded = {1'b0, acc_ff} + ROUND;
   assign angle   = rounded[31 -: ANGLE_BITS];
   assign done    = done_ff;

endmodule
